@@ rtl/spi_pkg.sv @@
// Shared constants for the segment/plane intersection block.
`default_nettype none

package spi_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Pipeline depth of spi_mul: partial products, pair sums, final sum.
    localparam int MUL_LAT = 3;

    // Configuration register indexes.
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_POINT_X  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_NORMAL_Z = 3'd5;

endpackage

`default_nettype wire

@@ rtl/segment_plane_intersect.sv @@
// Top level: segment against configured plane, fully pipelined.
`default_nettype none

// segment_plane_intersect
//
// Tests one segment A->B (Q15.16 at the default widths) against a plane given
// by a point P and a normal N held in six APB registers (byte address 4*i, or
// 8*i when WORD_BITS exceeds 32). Write the plane only while no item is in
// flight; pready is always high and reads return the register contents.
//
// Items enter on start; busy is tied low, so an item is taken every cycle.
// Each item yields exactly one result: done is high for one cycle with hit,
// degenerate, hit_x/y/z and offset_x/y/z. The receiver cannot stall and
// nothing here ever stalls, so results leave in item order.
//
// Throughput is one item per clock. An item passes the difference and magnitude
// registers, the dot-product multipliers and sums, the classify registers, the
// scaling multiplier and the restoring divider (one quotient bit per stage over
// WORD_BITS + 2 bits), then the output registers that raise done.
//
// Reset clears the pipeline valid bits and loads the plane to point (0,0,0)
// and normal (0,1.0,0); in-flight items are dropped.
module segment_plane_intersect #(
    parameter int  WORD_BITS = spi_pkg::WORD_BITS_DEF,
    parameter int  FRAC_BITS = spi_pkg::FRAC_BITS_DEF,
    localparam int BUS_BITS  = (WORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_LSB  = (WORD_BITS > 32) ? 3 : 2,
    localparam int ADDR_BITS = ADDR_LSB + spi_pkg::REG_IDX_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [BUS_BITS-1:0]   pwdata,
    output logic [BUS_BITS-1:0]        prdata,
    output logic                       pready,
    // item input
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [WORD_BITS-1:0] start_x,
    input  wire logic signed [WORD_BITS-1:0] start_y,
    input  wire logic signed [WORD_BITS-1:0] start_z,
    input  wire logic signed [WORD_BITS-1:0] end_x,
    input  wire logic signed [WORD_BITS-1:0] end_y,
    input  wire logic signed [WORD_BITS-1:0] end_z,
    // result output
    output logic                       done,
    output logic                       hit,
    output logic                       degenerate,
    output logic signed [WORD_BITS-1:0] hit_x,
    output logic signed [WORD_BITS-1:0] hit_y,
    output logic signed [WORD_BITS-1:0] hit_z,
    output logic signed [WORD_BITS-1:0] offset_x,
    output logic signed [WORD_BITS-1:0] offset_y,
    output logic signed [WORD_BITS-1:0] offset_z
);

    // Widths of the intermediate values.
    localparam int VB = WORD_BITS + 1;       // coordinate difference
    localparam int PB = VB + WORD_BITS;      // magnitude of one dot term
    localparam int SB = PB + 2;              // signed dot product
    localparam int MB = SB - 1;              // magnitude of a dot product
    localparam int QB = WORD_BITS + 2;       // quotient bits kept
    localparam int BB = MB + VB;             // magnitude of num * d
    localparam int XB = WORD_BITS + 4;       // intersection before saturation

    localparam int L       = spi_pkg::MUL_LAT;
    localparam int DIV_LAT = QB + 1;
    localparam int D_DEPTH = L + 4;                 // difference stage to scaling
    localparam int F_DEPTH = L + DIV_LAT;           // flags across scaling+divide
    localparam int S_DEPTH = 2 * L + DIV_LAT + 4;   // endpoints to the last stage
    localparam int V_DEPTH = 2 * L + DIV_LAT + 5;   // valid bits

    localparam logic [WORD_BITS-1:0] NORMAL_Y_RESET = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [XB-1:0] X_MAX =
        $signed({{(XB-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [XB-1:0] X_MIN =
        $signed({{(XB-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}});

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] a;
        logic [2:0][WORD_BITS-1:0] b;
        logic [2:0][VB-1:0]        v;
    } side_t;

    typedef struct packed {
        logic [2:0][VB-1:0] mag;
        logic [2:0]         neg;
    } dline_t;

    typedef struct packed {
        logic       hit;
        logic       deg;
        logic [2:0] qneg;
    } flag_t;

    function automatic logic signed [VB-1:0] sx(input logic [WORD_BITS-1:0] x);
        return {x[WORD_BITS-1], x};
    endfunction

    function automatic logic [VB-1:0] vabs(input logic signed [VB-1:0] x);
        return x[VB-1] ? $unsigned(-x) : $unsigned(x);
    endfunction

    function automatic logic [WORD_BITS-1:0] nabs(input logic signed [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? $unsigned(-x) : $unsigned(x);
    endfunction

    function automatic logic signed [SB-1:0] apply_sign(input logic [PB-1:0] m,
                                                        input logic neg);
        logic signed [SB-1:0] e;
        e = {{(SB-PB){1'b0}}, m};
        return neg ? -e : e;
    endfunction

    function automatic logic [MB-1:0] smag(input logic signed [SB-1:0] x);
        logic signed [SB-1:0] m;
        m = x[SB-1] ? -x : x;
        return m[MB-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] sat(input logic signed [XB-1:0] x);
        if (x > X_MAX)
            return W_MAX;
        else if (x < X_MIN)
            return W_MIN;
        else
            return x[WORD_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0]             point_reg  [3];
    logic [WORD_BITS-1:0]             normal_reg [3];
    logic                             wr_en;
    logic [spi_pkg::REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:ADDR_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                point_reg[k]  <= '0;
                normal_reg[k] <= (k == 1) ? NORMAL_Y_RESET : '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                spi_pkg::REG_POINT_X:  point_reg[0]  <= pwdata[WORD_BITS-1:0];
                spi_pkg::REG_POINT_Y:  point_reg[1]  <= pwdata[WORD_BITS-1:0];
                spi_pkg::REG_POINT_Z:  point_reg[2]  <= pwdata[WORD_BITS-1:0];
                spi_pkg::REG_NORMAL_X: normal_reg[0] <= pwdata[WORD_BITS-1:0];
                spi_pkg::REG_NORMAL_Y: normal_reg[1] <= pwdata[WORD_BITS-1:0];
                spi_pkg::REG_NORMAL_Z: normal_reg[2] <= pwdata[WORD_BITS-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            spi_pkg::REG_POINT_X:  prdata = BUS_BITS'(point_reg[0]);
            spi_pkg::REG_POINT_Y:  prdata = BUS_BITS'(point_reg[1]);
            spi_pkg::REG_POINT_Z:  prdata = BUS_BITS'(point_reg[2]);
            spi_pkg::REG_NORMAL_X: prdata = BUS_BITS'(normal_reg[0]);
            spi_pkg::REG_NORMAL_Y: prdata = BUS_BITS'(normal_reg[1]);
            spi_pkg::REG_NORMAL_Z: prdata = BUS_BITS'(normal_reg[2]);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input and valid line
    // ------------------------------------------------------------------
    logic                 accept;
    logic [WORD_BITS-1:0] in_a [3];
    logic [WORD_BITS-1:0] in_b [3];
    logic [V_DEPTH-1:0]   valid_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign in_a[0] = start_x;
    assign in_a[1] = start_y;
    assign in_a[2] = start_z;
    assign in_b[0] = end_x;
    assign in_b[1] = end_y;
    assign in_b[2] = end_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[V_DEPTH-2:0], accept};
    end

    // ------------------------------------------------------------------
    // Stage 1: differences. Group 0 is v = B - P, 1 is d = B - A, 2 is P - A.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] a1_reg [3];
    logic [WORD_BITS-1:0] b1_reg [3];
    logic signed [VB-1:0] diff1_reg [3][3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            a1_reg[k]       <= in_a[k];
            b1_reg[k]       <= in_b[k];
            diff1_reg[0][k] <= sx(in_b[k]) - sx(point_reg[k]);
            diff1_reg[1][k] <= sx(in_b[k]) - sx(in_a[k]);
            diff1_reg[2][k] <= sx(point_reg[k]) - sx(in_a[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes and signs for the dot-product multipliers
    // ------------------------------------------------------------------
    logic [VB-1:0]        mag2_reg  [3][3];
    logic [WORD_BITS-1:0] nmag2_reg [3];
    logic [8:0]           psgn_reg  [L+1];
    dline_t               dline_reg [D_DEPTH];
    dline_t               dline_in;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dline_in.mag[k] = vabs(diff1_reg[1][k]);
            dline_in.neg[k] = diff1_reg[1][k][VB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            nmag2_reg[k] <= nabs(normal_reg[k]);
            for (int g = 0; g < 3; g++)
            begin
                mag2_reg[g][k]       <= vabs(diff1_reg[g][k]);
                psgn_reg[0][g*3 + k] <= diff1_reg[g][k][VB-1] ^ normal_reg[k][WORD_BITS-1];
            end
        end
        for (int j = 1; j <= L; j++)
        begin
            psgn_reg[j] <= psgn_reg[j-1];
        end
        dline_reg[0] <= dline_in;
        for (int j = 1; j < D_DEPTH; j++)
        begin
            dline_reg[j] <= dline_reg[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Dot-product terms: nine multipliers, one per component and vector
    // ------------------------------------------------------------------
    logic [PB-1:0] prod [3][3];

    for (genvar g = 0; g < 3; g++)
    begin : g_dot_vec
        for (genvar k = 0; k < 3; k++)
        begin : g_dot_comp
            spi_mul #(
                .A_BITS(VB),
                .B_BITS(WORD_BITS)
            ) u_mul (
                .clk(clk),
                .a  (mag2_reg[g][k]),
                .b  (nmag2_reg[k]),
                .p  (prod[g][k])
            );
        end
    end

    // Signed terms, then the three dot sums: l, den, num.
    logic signed [SB-1:0] term_reg [3][3];
    logic signed [SB-1:0] dot_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 3; g++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                term_reg[g][k] <= apply_sign(prod[g][k], psgn_reg[L][g*3 + k]);
            end
            dot_reg[g] <= term_reg[g][0] + term_reg[g][1] + term_reg[g][2];
        end
    end

    // ------------------------------------------------------------------
    // Classify and take magnitudes for the scaling step
    // ------------------------------------------------------------------
    flag_t         flag8_reg;
    logic [MB-1:0] numm8_reg;
    logic [MB-1:0] denm8_reg;

    always_ff @(posedge clk)
    begin
        flag8_reg.hit <= dot_reg[0][SB-1];
        flag8_reg.deg <= (dot_reg[1] == '0);
        for (int k = 0; k < 3; k++)
        begin
            flag8_reg.qneg[k] <= dot_reg[2][SB-1] ^ dot_reg[1][SB-1]
                               ^ dline_reg[D_DEPTH-2].neg[k];
        end
        numm8_reg <= smag(dot_reg[2]);
        denm8_reg <= smag(dot_reg[1]);
    end

    // num * d_k, then divide by den; hold den and flags alongside.
    logic [BB-1:0] ndp [3];
    logic [QB-1:0] quo [3];
    logic [2:0]    ovf;
    logic [MB-1:0] denl_reg [L];
    flag_t         flag_reg [F_DEPTH];

    always_ff @(posedge clk)
    begin
        denl_reg[0] <= denm8_reg;
        for (int j = 1; j < L; j++)
        begin
            denl_reg[j] <= denl_reg[j-1];
        end
        flag_reg[0] <= flag8_reg;
        for (int j = 1; j < F_DEPTH; j++)
        begin
            flag_reg[j] <= flag_reg[j-1];
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_scale
        spi_mul #(
            .A_BITS(MB),
            .B_BITS(VB)
        ) u_mul (
            .clk(clk),
            .a  (numm8_reg),
            .b  (dline_reg[D_DEPTH-1].mag[k]),
            .p  (ndp[k])
        );

        spi_div #(
            .P_BITS(BB),
            .D_BITS(MB),
            .Q_BITS(QB)
        ) u_div (
            .clk(clk),
            .num(ndp[k]),
            .den(denl_reg[L-1]),
            .quo(quo[k]),
            .ovf(ovf[k])
        );
    end

    // ------------------------------------------------------------------
    // Endpoints and v travel beside the arithmetic to the last stage
    // ------------------------------------------------------------------
    side_t side_reg [S_DEPTH];
    side_t side_in;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            side_in.a[k] = a1_reg[k];
            side_in.b[k] = b1_reg[k];
            side_in.v[k] = diff1_reg[0][k];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int j = 1; j < S_DEPTH; j++)
        begin
            side_reg[j] <= side_reg[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Last stage: A + signed quotient, saturate, select by hit/degenerate
    // ------------------------------------------------------------------
    side_t                side_out;
    flag_t                flag_out;
    logic signed [XB-1:0] qext [3];
    logic signed [XB-1:0] aext [3];
    logic signed [XB-1:0] xsum [3];
    logic [WORD_BITS-1:0] pos  [3];
    logic [WORD_BITS-1:0] pos_next [3];
    logic [WORD_BITS-1:0] off_next [3];

    always_comb
    begin
        side_out = side_reg[S_DEPTH-1];
        flag_out = flag_reg[F_DEPTH-1];
        for (int k = 0; k < 3; k++)
        begin
            qext[k] = {{(XB-QB){1'b0}}, quo[k]};
            aext[k] = {{(XB-WORD_BITS){side_out.a[k][WORD_BITS-1]}}, side_out.a[k]};
            xsum[k] = aext[k] + (flag_out.qneg[k] ? -qext[k] : qext[k]);
            // Quotient too large for QB bits: the result is past either limit.
            if (ovf[k])
                pos[k] = flag_out.qneg[k] ? W_MIN : W_MAX;
            else
                pos[k] = sat(xsum[k]);

            if (!flag_out.hit)
            begin
                pos_next[k] = '0;
                off_next[k] = '0;
            end
            else
            begin
                off_next[k] = sat({{(XB-VB){side_out.v[k][VB-1]}}, side_out.v[k]});
                pos_next[k] = flag_out.deg ? side_out.b[k] : pos[k];
            end
        end
    end

    logic                 done_reg;
    logic                 hit_reg;
    logic                 degenerate_reg;
    logic [WORD_BITS-1:0] pos_reg [3];
    logic [WORD_BITS-1:0] off_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[V_DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= flag_out.hit;
        degenerate_reg <= flag_out.hit & flag_out.deg;
        for (int k = 0; k < 3; k++)
        begin
            pos_reg[k] <= pos_next[k];
            off_reg[k] <= off_next[k];
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign degenerate = degenerate_reg;
    assign hit_x      = pos_reg[0];
    assign hit_y      = pos_reg[1];
    assign hit_z      = pos_reg[2];
    assign offset_x   = off_reg[0];
    assign offset_y   = off_reg[1];
    assign offset_z   = off_reg[2];

endmodule

`default_nettype wire

@@ rtl/spi_mul.sv @@
// Pipelined unsigned multiplier built from four registered partial products.
`default_nettype none

module spi_mul #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic [A_BITS-1:0]        a,
    input  wire logic [B_BITS-1:0]        b,
    output logic [A_BITS+B_BITS-1:0]      p
);

    localparam int PARTS = 4;
    localparam int CH    = (A_BITS + PARTS - 1) / PARTS;
    localparam int AW    = PARTS * CH;
    localparam int PW    = CH + B_BITS;
    localparam int HW    = 2 * CH + B_BITS;
    localparam int FW    = 4 * CH + B_BITS;

    logic [AW-1:0]            a_ext;
    logic [PW-1:0]            pp_reg [PARTS];
    logic [HW-1:0]            lo_reg;
    logic [HW-1:0]            hi_reg;
    logic [FW-1:0]            sum_next;
    logic [A_BITS+B_BITS-1:0] p_reg;

    assign a_ext    = AW'(a);
    assign sum_next = FW'(lo_reg) + (FW'(hi_reg) << (2 * CH));

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < PARTS; j++)
        begin
            pp_reg[j] <= PW'(a_ext[j*CH +: CH]) * PW'(b);
        end
        lo_reg <= HW'(pp_reg[0]) + (HW'(pp_reg[1]) << CH);
        hi_reg <= HW'(pp_reg[2]) + (HW'(pp_reg[3]) << CH);
        p_reg  <= sum_next[A_BITS+B_BITS-1:0];
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ rtl/spi_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`default_nettype none

module spi_div #(
    parameter int P_BITS = 99,
    parameter int D_BITS = 66,
    parameter int Q_BITS = 34
) (
    input  wire logic              clk,
    input  wire logic [P_BITS-1:0] num,
    input  wire logic [D_BITS-1:0] den,
    output logic [Q_BITS-1:0]      quo,
    output logic                   ovf
);

    localparam int RB = (P_BITS > D_BITS + Q_BITS) ? P_BITS : D_BITS + Q_BITS;

    logic [RB-1:0]     rem_reg [Q_BITS+1];
    logic [D_BITS-1:0] den_reg [Q_BITS+1];
    logic [Q_BITS-1:0] quo_reg [Q_BITS+1];
    logic [Q_BITS:0]   ovf_reg;
    logic [RB:0]       diff    [Q_BITS];

    // Trial subtract of the divisor aligned to the bit this stage decides.
    always_comb
    begin
        for (int i = 0; i < Q_BITS; i++)
        begin
            diff[i] = {1'b0, rem_reg[i]} - {1'b0, RB'(den_reg[i]) << (Q_BITS - 1 - i)};
        end
    end

    always_ff @(posedge clk)
    begin
        // Quotient does not fit in Q_BITS: flag it and let the stages run.
        rem_reg[0] <= RB'(num);
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= (RB'(num) >> Q_BITS) >= RB'(den);
        for (int i = 0; i < Q_BITS; i++)
        begin
            rem_reg[i+1] <= diff[i][RB] ? rem_reg[i] : diff[i][RB-1:0];
            quo_reg[i+1] <= quo_reg[i] | (Q_BITS'(!diff[i][RB]) << (Q_BITS - 1 - i));
            den_reg[i+1] <= den_reg[i];
            ovf_reg[i+1] <= ovf_reg[i];
        end
    end

    assign quo = quo_reg[Q_BITS];
    assign ovf = ovf_reg[Q_BITS];

endmodule

`default_nettype wire

@@ tb/sv/spi_checker.sv @@
// Checker for segment_plane_intersect: tracks the plane, predicts each item's result, compares.
`default_nettype none

module spi_checker #(
    parameter int W         = spi_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = 2 + spi_pkg::REG_IDX_BITS,
    parameter int BUS_BITS  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [BUS_BITS-1:0]   pwdata,
    input  wire logic [BUS_BITS-1:0]   prdata,
    input  wire logic                  pready,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic signed [W-1:0]   start_x,
    input  wire logic signed [W-1:0]   start_y,
    input  wire logic signed [W-1:0]   start_z,
    input  wire logic signed [W-1:0]   end_x,
    input  wire logic signed [W-1:0]   end_y,
    input  wire logic signed [W-1:0]   end_z,
    input  wire logic                  done,
    input  wire logic                  hit,
    input  wire logic                  degenerate,
    input  wire logic signed [W-1:0]   hit_x,
    input  wire logic signed [W-1:0]   hit_y,
    input  wire logic signed [W-1:0]   hit_z,
    input  wire logic signed [W-1:0]   offset_x,
    input  wire logic signed [W-1:0]   offset_y,
    input  wire logic signed [W-1:0]   offset_z,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_BITS = spi_pkg::REG_IDX_BITS;

    typedef struct packed {
        logic                hit;
        logic                degenerate;
        logic [2:0][W-1:0]   pos;
        logic [2:0][W-1:0]   vec;
    } seg_result_t;

    localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (W - 1)) - 128'sd1;
    localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (W - 1));

    logic signed [W-1:0] plane_pt  [3];
    logic signed [W-1:0] plane_nrm [3];
    seg_result_t         due_results [$];
    string               axis_name [3] = '{"x", "y", "z"};

    function automatic logic [W-1:0] clamp_word(input logic signed [127:0] x);
        if (x > SAT_HI)
            return SAT_HI[W-1:0];
        if (x < SAT_LO)
            return SAT_LO[W-1:0];
        return x[W-1:0];
    endfunction

    // Exact-width intersection; 128 bits hold every product and quotient here.
    function automatic seg_result_t intersect_segment(
        input logic signed [W-1:0] ax, ay, az, bx, by, bz);
        logic signed [127:0] a [3];
        logic signed [127:0] b [3];
        logic signed [127:0] p [3];
        logic signed [127:0] n [3];
        logic signed [127:0] v [3];
        logic signed [127:0] d [3];
        logic signed [127:0] pa [3];
        logic signed [127:0] side, den, num, q;
        seg_result_t r;
        a[0] = ax; a[1] = ay; a[2] = az;
        b[0] = bx; b[1] = by; b[2] = bz;
        for (int k = 0; k < 3; k++)
        begin
            p[k]  = plane_pt[k];
            n[k]  = plane_nrm[k];
            v[k]  = b[k] - p[k];
            d[k]  = b[k] - a[k];
            pa[k] = p[k] - a[k];
        end
        r = '0;
        side = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
        if (side < 0)
        begin
            r.hit = 1'b1;
            for (int k = 0; k < 3; k++)
                r.vec[k] = clamp_word(v[k]);
            den = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
            if (den == 0)
            begin
                r.degenerate = 1'b1;
                for (int k = 0; k < 3; k++)
                    r.pos[k] = b[k][W-1:0];
            end
            else
            begin
                num = pa[0] * n[0] + pa[1] * n[1] + pa[2] * n[2];
                for (int k = 0; k < 3; k++)
                begin
                    q = (num * d[k]) / den;   // truncates toward zero
                    r.pos[k] = clamp_word(a[k] + q);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [W-1:0] plane_reg(input logic [IDX_BITS-1:0] idx);
        case (idx)
            spi_pkg::REG_POINT_X:  return plane_pt[0];
            spi_pkg::REG_POINT_Y:  return plane_pt[1];
            spi_pkg::REG_POINT_Z:  return plane_pt[2];
            spi_pkg::REG_NORMAL_X: return plane_nrm[0];
            spi_pkg::REG_NORMAL_Y: return plane_nrm[1];
            spi_pkg::REG_NORMAL_Z: return plane_nrm[2];
            default:               return '0;
        endcase
    endfunction

    task automatic flag(input string what, input logic [W-1:0] want_v, got_v);
        fail_count++;
        $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        seg_result_t want, got;
        logic [IDX_BITS-1:0] idx;
        if (!rst_n)
        begin
            plane_pt     = '{default: '0};
            plane_nrm    = '{default: '0};
            plane_nrm[1] = W'(1) << spi_pkg::FRAC_BITS_DEF;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                got.hit        = hit;
                got.degenerate = degenerate;
                got.pos        = {hit_z, hit_y, hit_x};
                got.vec        = {offset_z, offset_y, offset_x};
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, got hit %b pos %h vec %h",
                             $time, got.hit, got.pos, got.vec);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.hit !== want.hit)
                        flag("hit", W'(want.hit), W'(got.hit));
                    if (got.degenerate !== want.degenerate)
                        flag("degenerate", W'(want.degenerate), W'(got.degenerate));
                    for (int k = 0; k < 3; k++)
                    begin
                        if (got.pos[k] !== want.pos[k])
                            flag($sformatf("hit_%s", axis_name[k]), want.pos[k], got.pos[k]);
                        if (got.vec[k] !== want.vec[k])
                            flag($sformatf("offset_%s", axis_name[k]), want.vec[k], got.vec[k]);
                    end
                end
            end

            if (psel && penable && pready)
            begin
                idx = paddr[ADDR_BITS-1 -: IDX_BITS];
                if (pwrite)
                begin
                    case (idx)
                        spi_pkg::REG_POINT_X:  plane_pt[0]  = pwdata[W-1:0];
                        spi_pkg::REG_POINT_Y:  plane_pt[1]  = pwdata[W-1:0];
                        spi_pkg::REG_POINT_Z:  plane_pt[2]  = pwdata[W-1:0];
                        spi_pkg::REG_NORMAL_X: plane_nrm[0] = pwdata[W-1:0];
                        spi_pkg::REG_NORMAL_Y: plane_nrm[1] = pwdata[W-1:0];
                        spi_pkg::REG_NORMAL_Z: plane_nrm[2] = pwdata[W-1:0];
                        default: ;   // drop writes to unused indexes
                    endcase
                end
                else if (idx <= spi_pkg::REG_NORMAL_Z && prdata[W-1:0] !== plane_reg(idx))
                    flag($sformatf("prdata[%0d]", idx), plane_reg(idx), prdata[W-1:0]);
            end

            if (start && !busy)
                due_results.push_back(
                    intersect_segment(start_x, start_y, start_z, end_x, end_y, end_z));
            pending = due_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench top for segment_plane_intersect: clock, reset, stimulus and verdict.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = spi_pkg::WORD_BITS_DEF;
    localparam int IDX_BITS  = spi_pkg::REG_IDX_BITS;
    localparam int ADDR_LSB  = 2;
    localparam int ADDR_BITS = ADDR_LSB + IDX_BITS;
    localparam int BUS_BITS  = 32;
    localparam int LATENCY   = W + 14;
    localparam int LIMIT     = 100000;   // cycles before the watchdog ends the run
    localparam int PHASES    = 7;
    localparam int PHASE_LEN = 280;

    // Indexes the block decodes but does not implement.
    localparam logic [IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPARE_B = 3'd7;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = W'(1) << spi_pkg::FRAC_BITS_DEF;
    localparam logic [W-1:0] NEG1 = -ONE;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [BUS_BITS-1:0]  pwdata;
    logic [BUS_BITS-1:0]  prdata;
    logic pready;
    logic start, busy;
    logic signed [W-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic done, hit, degenerate;
    logic signed [W-1:0] hit_x, hit_y, hit_z, offset_x, offset_y, offset_z;
    int fail_count;
    int pending;

    // Stimulus-side copy of the plane, used only to shape segments.
    logic signed [W-1:0] cur_pt  [3];
    logic signed [W-1:0] cur_nrm [3];

    segment_plane_intersect dut (
        .clk, .rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy,
        .start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
        .done, .hit, .degenerate,
        .hit_x, .hit_y, .hit_z, .offset_x, .offset_y, .offset_z
    );

    spi_checker #(.W(W), .ADDR_BITS(ADDR_BITS), .BUS_BITS(BUS_BITS)) u_checker (
        .clk, .rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy,
        .start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
        .done, .hit, .degenerate,
        .hit_x, .hit_y, .hit_z, .offset_x, .offset_y, .offset_z,
        .fail_count, .pending
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the stimulus or the drain hangs.
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Mix of extremes, full-range words and scaled-down words so that small
    // coordinates, large ones and saturating ones all show up.
    function automatic logic [W-1:0] rand_word();
        int unsigned pick;
        logic signed [W-1:0] raw;
        pick = $urandom_range(0, 99);
        raw  = signed'(W'($urandom));
        if (pick < 8)
        begin
            case ($urandom_range(0, 5))
                0:       return MAXV;
                1:       return MINV;
                2:       return '0;
                3:       return '1;
                4:       return ONE;
                default: return NEG1;
            endcase
        end
        if (pick < 40)
            return raw;
        return raw >>> $urandom_range(4, 24);
    endfunction

    // Both APB accesses: setup cycle, then access until pready, then release
    // the bus for one cycle so back-to-back calls never retime psel in one step.
    task automatic reg_access(input logic wr, input logic [IDX_BITS-1:0] idx,
                              input logic [W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, {ADDR_LSB{1'b0}}};
        pwdata  <= BUS_BITS'(data);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_back_plane();
        for (int i = spi_pkg::REG_POINT_X; i <= spi_pkg::REG_NORMAL_Z; i++)
            reg_access(1'b0, IDX_BITS'(i), '0);
    endtask

    task automatic set_plane(input logic [W-1:0] px, py, pz, nx, ny, nz);
        reg_access(1'b1, spi_pkg::REG_POINT_X,  px);
        reg_access(1'b1, spi_pkg::REG_POINT_Y,  py);
        reg_access(1'b1, spi_pkg::REG_POINT_Z,  pz);
        reg_access(1'b1, spi_pkg::REG_NORMAL_X, nx);
        reg_access(1'b1, spi_pkg::REG_NORMAL_Y, ny);
        reg_access(1'b1, spi_pkg::REG_NORMAL_Z, nz);
        cur_pt  = '{px, py, pz};
        cur_nrm = '{nx, ny, nz};
        read_back_plane();
    endtask

    // Raise start with the segment and hold it until the block takes the item.
    task automatic send_segment(input logic [W-1:0] ax, ay, az, bx, by, bz);
        start   <= 1'b1;
        start_x <= ax;
        start_y <= ay;
        start_z <= az;
        end_x   <= bx;
        end_y   <= by;
        end_z   <= bz;
        do @(posedge clk); while (busy);
    endtask

    // Drop start for the gap that n asks for; scramble the payload so ignored data is exercised.
    task automatic hold_off(input int n);
        start   <= 1'b0;
        start_x <= W'($urandom);
        start_y <= W'($urandom);
        start_z <= W'($urandom);
        end_x   <= W'($urandom);
        end_y   <= W'($urandom);
        end_z   <= W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // Pause the sender until every item in flight has produced its result.
    // Sample pending on the falling edge, away from the checker's update.
    task automatic wait_all_results();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // One random segment: most are free, the rest shaped against the current plane or corner words.
    task automatic send_random_segment();
        logic [W-1:0] a [3];
        logic [W-1:0] b [3];
        int unsigned kind;
        int unsigned s1, s2;
        kind = $urandom_range(0, 99);
        s1   = $urandom_range(0, 20);
        s2   = $urandom_range(0, 20);
        for (int k = 0; k < 3; k++)
        begin
            a[k] = rand_word();
            b[k] = rand_word();
        end
        if (kind < 60)
            ;   // free segment
        else if (kind < 72)
        begin
            // move only along axes the normal ignores: parallel to the plane
            for (int k = 0; k < 3; k++)
                if (cur_nrm[k] != 0)
                    b[k] = a[k];
        end
        else if (kind < 80)
            b = a;                      // zero length
        else if (kind < 86)
        begin
            // end exactly on the plane
            for (int k = 0; k < 3; k++)
                b[k] = cur_pt[k];
        end
        else if (kind < 94)
        begin
            // start in front, end behind: a proper crossing
            for (int k = 0; k < 3; k++)
            begin
                a[k] = cur_pt[k] + (cur_nrm[k] >>> s1);
                b[k] = cur_pt[k] - (cur_nrm[k] >>> s2);
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                a[k] = $urandom_range(0, 1) ? MAXV : MINV;
                b[k] = $urandom_range(0, 1) ? MAXV : MINV;
            end
        end
        send_segment(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    initial
    begin
        int n_items;
        // Drive every input to a known value before the first edge.
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        start_x <= '0;
        start_y <= '0;
        start_z <= '0;
        end_x   <= '0;
        end_y   <= '0;
        end_z   <= '0;
        cur_pt  = '{default: '0};
        cur_nrm = '{'0, ONE, '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset plane: point at the origin, normal +y.
        read_back_plane();

        // Directed: plain crossing, midpoint crossing, end on the plane,
        // end in front, parallel, zero length, corner words.
        send_segment('0, ONE, '0, '0, NEG1, '0);
        send_segment(ONE, 2 * ONE, NEG1, 3 * ONE, -2 * ONE, ONE);
        send_segment('0, ONE, '0, W'(5), '0, W'(7));
        send_segment('0, NEG1, '0, '0, ONE, '0);
        send_segment('0, NEG1, '0, 7 * ONE, NEG1, -3 * ONE);
        send_segment(ONE, NEG1, ONE, ONE, NEG1, ONE);
        send_segment(MAXV, MAXV, MAXV, MINV, MINV, MINV);
        send_segment(MINV, MINV, MINV, MAXV, MAXV, MAXV);
        send_segment(MINV, MAXV, MINV, MAXV, '1, MAXV);
        send_segment('0, MAXV, '0, MAXV, '1, MINV);
        send_segment('0, W'(1), '0, MAXV, MINV, MAXV);
        send_segment('1, '1, '1, '1, '1, '1);
        wait_all_results();

        // Unused indexes must not disturb the plane.
        reg_access(1'b1, REG_SPARE_A, W'($urandom));
        reg_access(1'b1, REG_SPARE_B, W'($urandom));

        // Extreme plane: offsets saturate, crossings land on the word limits.
        set_plane(MINV, MAXV, MINV, MINV, MAXV, MINV);
        send_segment(MINV, MAXV, MINV, MAXV, MINV, MAXV);
        send_segment('0, '0, '0, MAXV, MINV, MAXV);
        send_segment(MAXV, MINV, MAXV, MAXV, MINV, MAXV);
        send_segment(MAXV, MAXV, MAXV, MAXV, MINV, MAXV);
        send_segment(MINV, MINV, MINV, W'(1), '0, '1);
        wait_all_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_plane('0, '0, '0, '0, ONE, '0);
                1: set_plane(MINV, MAXV, MINV, MINV, MAXV, MINV);
                2: set_plane(MAXV, MINV, MAXV, MAXV, MINV, MAXV);
                3: set_plane(rand_word(), rand_word(), rand_word(), '0, '0, ONE);
                4: set_plane(rand_word(), rand_word(), rand_word(), '0, '0, '0);
                default: set_plane(rand_word(), rand_word(), rand_word(),
                                   rand_word(), rand_word(), rand_word());
            endcase

            // A null normal never hits; keep that phase short.
            n_items = (ph == 4) ? 60 : PHASE_LEN;
            for (int i = 0; i < n_items; i++)
            begin
                send_random_segment();
                // Phase 3 streams back to back with no random gaps; only the mid-phase drain pauses it.
                if (ph != 3 && $urandom_range(0, 99) < 5)
                    hold_off($urandom_range(1, 2));
                if (i == n_items / 2)
                    wait_all_results();
            end
            wait_all_results();
        end

        // Let any stray result surface before the verdict.
        hold_off(2 * LATENCY);
        wait_all_results();

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
